// ----- rtl/conv_window_address_generator_core_macros.svh -----
// ----------------------------------------------------------------------------
// conv_window_address_generator_core_macros
// Assertion helpers used by the window address generator core.
// ----------------------------------------------------------------------------
`ifndef CONV_WINDOW_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define CONV_WINDOW_ADDRESS_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CWAG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define CWAG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cwag_pkg.sv -----
// ----------------------------------------------------------------------------
// cwag_pkg
// Types and codes for the convolution window address generator.
// ----------------------------------------------------------------------------
package cwag_pkg;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL_Y = 4'b0010,
      ST_MUL_X = 4'b0100,
      ST_WALK  = 4'b1000
   } state_type;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 13;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IN_HEIGHT     = 3'd0,
      CSR_IN_WIDTH      = 3'd1,
      CSR_KERNEL_HEIGHT = 3'd2,
      CSR_KERNEL_WIDTH  = 3'd3,
      CSR_STRIDE_Y      = 3'd4,
      CSR_STRIDE_X      = 3'd5,
      CSR_PAD_TOP       = 3'd6,
      CSR_PAD_LEFT      = 3'd7
   } csr_index_type;

   localparam int BATCH_WIDTH   = 8;
   localparam int CHANNEL_WIDTH = 12;
   localparam int EXTENT_WIDTH  = 13;
   localparam int KSIZE_WIDTH   = 4;
   localparam int STRIDE_WIDTH  = 7;
   localparam int PAD_WIDTH     = 8;

   // range check status for one axis
   typedef struct packed {
      logic ok_now;   // current coordinate inside the image
      logic ok_next;  // coordinate one dilation step on is inside
   } range_flags_type;

endpackage

// ----- rtl/conv_window_address_generator_core.sv -----
// ----------------------------------------------------------------------------
// conv_window_address_generator_core
// 2-D convolution sliding-window address generator.
// ----------------------------------------------------------------------------
// Each request item names one output element (batch, channel, out_y, out_x).
// The core walks the kernel window row-major (kernel row outer, column inner)
// and sends one response item per tap that lands inside the input image,
// tagged with the request. The final tap carries last_of_window. A window
// with no tap inside gives a single item with window_empty and
// last_of_window set and zero coordinates.
//
// Timing: after the accepting edge the MUL_Y and MUL_X states run the window
// origin (out * stride - pad) for rows, then columns, through a single
// multiplier; after that the walk visits one kernel position per cycle and
// ends early once the last inside tap is sent. Kernel sizes are clamped to
// MAX_KERNEL. req_ready comes back in the cycle after the walk, so a new
// request is not taken before the last one is through. When one kernel
// size is zero the other one is still stepped through before the empty item
// goes out. Each response stall holds the walk for that cycle. req_ready is
// high only between requests; a response left waiting in the output register
// does not block the next request.
//
// Configuration is written through csr_write_enable/csr_index/csr_write_data;
// the user must write it only while the core is idle, which the core itself
// does not enforce. Image sizes above 2^COORD_WIDTH are clamped.
// ----------------------------------------------------------------------------
`include "conv_window_address_generator_core_macros.svh"

module conv_window_address_generator_core #(
   parameter int MAX_KERNEL  = 8,
   parameter int COORD_WIDTH = 12,
   parameter int DILATION_Y  = 1,
   parameter int DILATION_X  = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // configuration
   input  logic                                    csr_write_enable,
   input  logic [cwag_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [cwag_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [cwag_pkg::BATCH_WIDTH-1:0]        req_batch,
   input  logic [cwag_pkg::CHANNEL_WIDTH-1:0]      req_channel,
   input  logic [COORD_WIDTH-1:0]                  req_out_y,
   input  logic [COORD_WIDTH-1:0]                  req_out_x,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [cwag_pkg::BATCH_WIDTH-1:0]        rsp_tag_batch,
   output logic [cwag_pkg::CHANNEL_WIDTH-1:0]      rsp_tag_channel,
   output logic [COORD_WIDTH-1:0]                  rsp_window_out_y,
   output logic [COORD_WIDTH-1:0]                  rsp_window_out_x,
   output logic [COORD_WIDTH-1:0]                  rsp_in_y,
   output logic [COORD_WIDTH-1:0]                  rsp_in_x,
   output logic                                    rsp_last_of_window,
   output logic                                    rsp_window_empty
);
   import cwag_pkg::*;

   // signed working width: product of coordinate and stride, plus sign and
   // headroom for the dilation offsets
   localparam int SW  = COORD_WIDTH + STRIDE_WIDTH + 2;
   localparam int PW  = COORD_WIDTH + STRIDE_WIDTH;
   localparam int KCW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   localparam logic [SW-1:0]          EXT_LIMIT = SW'(1) << COORD_WIDTH;
   localparam logic [KSIZE_WIDTH-1:0] KMAX      = KSIZE_WIDTH'(MAX_KERNEL);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [EXTENT_WIDTH-1:0] in_height_ff, in_width_ff;
   logic [KSIZE_WIDTH-1:0]  kernel_height_ff, kernel_width_ff;
   logic [STRIDE_WIDTH-1:0] stride_y_ff, stride_x_ff;
   logic [PAD_WIDTH-1:0]    pad_top_ff, pad_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff     <= EXTENT_WIDTH'(32);
         in_width_ff      <= EXTENT_WIDTH'(32);
         kernel_height_ff <= KSIZE_WIDTH'(3);
         kernel_width_ff  <= KSIZE_WIDTH'(3);
         stride_y_ff      <= STRIDE_WIDTH'(1);
         stride_x_ff      <= STRIDE_WIDTH'(1);
         pad_top_ff       <= '0;
         pad_left_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_HEIGHT:     in_height_ff     <= csr_write_data;
            CSR_IN_WIDTH:      in_width_ff      <= csr_write_data;
            CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_write_data[KSIZE_WIDTH-1:0];
            CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_write_data[KSIZE_WIDTH-1:0];
            CSR_STRIDE_Y:      stride_y_ff      <= csr_write_data[STRIDE_WIDTH-1:0];
            CSR_STRIDE_X:      stride_x_ff      <= csr_write_data[STRIDE_WIDTH-1:0];
            CSR_PAD_TOP:       pad_top_ff       <= csr_write_data[PAD_WIDTH-1:0];
            CSR_PAD_LEFT:      pad_left_ff      <= csr_write_data[PAD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamped kernel sizes and image extents
   logic [KSIZE_WIDTH-1:0] kh_eff, kw_eff;
   logic [SW-1:0]          ext_y, ext_x;

   assign kh_eff = (kernel_height_ff > KMAX) ? KMAX : kernel_height_ff;
   assign kw_eff = (kernel_width_ff > KMAX) ? KMAX : kernel_width_ff;
   assign ext_y  = (SW'(in_height_ff) > EXT_LIMIT) ? EXT_LIMIT : SW'(in_height_ff);
   assign ext_x  = (SW'(in_width_ff) > EXT_LIMIT) ? EXT_LIMIT : SW'(in_width_ff);

   // ---------------------------------------------------------------------
   // sequencer state and walk registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [BATCH_WIDTH-1:0]   held_batch_ff;
   logic [CHANNEL_WIDTH-1:0] held_channel_ff;
   logic [COORD_WIDTH-1:0]   held_out_y_ff, held_out_x_ff;

   logic [KCW-1:0]       ky_ff, ky_in, kx_ff, kx_in;
   logic signed [SW-1:0] y_ff, y_in, x_ff, x_in, xs_ff, xs_in;
   logic                 emitted_ff, emitted_in;

   logic req_accept;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // shared origin multiplier: rows in MUL_Y, columns in MUL_X
   logic [COORD_WIDTH-1:0]  mul_coord;
   logic [STRIDE_WIDTH-1:0] mul_stride;
   logic [PAD_WIDTH-1:0]    mul_pad;
   logic [PW-1:0]           mul_prod;
   logic signed [SW-1:0]    origin;

   always_comb begin
      if (state_ff == ST_MUL_X) begin
         mul_coord  = held_out_x_ff;
         mul_stride = stride_x_ff;
         mul_pad    = pad_left_ff;
      end else begin
         mul_coord  = held_out_y_ff;
         mul_stride = stride_y_ff;
         mul_pad    = pad_top_ff;
      end
   end

   assign mul_prod = PW'(mul_coord) * PW'(mul_stride);
   assign origin   = $signed(SW'(mul_prod)) - $signed(SW'(mul_pad));

   // bounds tests on the current tap
   range_flags_type y_flags, x_flags;

   cwag_range_check #(.SW(SW), .STEP(DILATION_Y)) u_check_y (
      .coord  (y_ff),
      .extent (ext_y),
      .flags  (y_flags)
   );

   cwag_range_check #(.SW(SW), .STEP(DILATION_X)) u_check_x (
      .coord  (x_ff),
      .extent (ext_x),
      .flags  (x_flags)
   );

   // kernel position tests, one bit wider than the size registers
   logic row_more, col_more, in_kernel, final_pos;
   logic tap_ok, tap_last;

   assign row_more  = ((5'(ky_ff) + 5'd1) < 5'(kh_eff));
   assign col_more  = ((5'(kx_ff) + 5'd1) < 5'(kw_eff));
   assign in_kernel = (5'(ky_ff) < 5'(kh_eff)) && (5'(kx_ff) < 5'(kw_eff));
   assign final_pos = !row_more && !col_more;

   // inside taps form a rectangle, so the tap is last when neither the next
   // column nor the next row is inside
   assign tap_ok   = in_kernel && y_flags.ok_now && x_flags.ok_now;
   assign tap_last = tap_ok && !(col_more && x_flags.ok_next)
                            && !(row_more && y_flags.ok_next);

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [BATCH_WIDTH-1:0]   rsp_batch_ff;
   logic [CHANNEL_WIDTH-1:0] rsp_channel_ff;
   logic [COORD_WIDTH-1:0]   rsp_out_y_ff, rsp_out_x_ff, rsp_in_y_ff, rsp_in_x_ff;
   logic                     rsp_last_ff, rsp_empty_ff;

   logic slot_free, rsp_load, load_empty, load_last;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign load_empty = !tap_ok && final_pos && !emitted_ff;
   assign rsp_load   = (state_ff == ST_WALK) && slot_free && (tap_ok || load_empty);
   assign load_last  = tap_ok ? tap_last : 1'b1;

   always_comb begin
      state_in   = state_ff;
      ky_in      = ky_ff;
      kx_in      = kx_ff;
      y_in       = y_ff;
      x_in       = x_ff;
      xs_in      = xs_ff;
      emitted_in = emitted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in   = ST_MUL_Y;
               ky_in      = '0;
               kx_in      = '0;
               emitted_in = 1'b0;
            end
         end
         ST_MUL_Y: begin
            y_in     = origin;
            state_in = ST_MUL_X;
         end
         ST_MUL_X: begin
            x_in     = origin;
            xs_in    = origin;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (slot_free) begin
               if (tap_ok) emitted_in = 1'b1;
               if (final_pos || tap_last) begin
                  state_in = ST_IDLE;
               end else if (col_more) begin
                  kx_in = kx_ff + KCW'(1);
                  x_in  = x_ff + $signed(SW'(DILATION_X));
               end else begin
                  kx_in = '0;
                  x_in  = xs_ff;
                  ky_in = ky_ff + KCW'(1);
                  y_in  = y_ff + $signed(SW'(DILATION_Y));
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         emitted_ff   <= 1'b0;
         ky_ff        <= '0;
         kx_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         emitted_ff   <= emitted_in;
         ky_ff        <= ky_in;
         kx_ff        <= kx_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff  <= y_in;
      x_ff  <= x_in;
      xs_ff <= xs_in;
      if (req_accept) begin
         held_batch_ff   <= req_batch;
         held_channel_ff <= req_channel;
         held_out_y_ff   <= req_out_y;
         held_out_x_ff   <= req_out_x;
      end
      if (rsp_load) begin
         rsp_batch_ff   <= held_batch_ff;
         rsp_channel_ff <= held_channel_ff;
         rsp_out_y_ff   <= held_out_y_ff;
         rsp_out_x_ff   <= held_out_x_ff;
         rsp_in_y_ff    <= tap_ok ? y_ff[COORD_WIDTH-1:0] : '0;
         rsp_in_x_ff    <= tap_ok ? x_ff[COORD_WIDTH-1:0] : '0;
         rsp_last_ff    <= load_last;
         rsp_empty_ff   <= !tap_ok;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tag_batch      = rsp_batch_ff;
   assign rsp_tag_channel    = rsp_channel_ff;
   assign rsp_window_out_y   = rsp_out_y_ff;
   assign rsp_window_out_x   = rsp_out_x_ff;
   assign rsp_in_y           = rsp_in_y_ff;
   assign rsp_in_x           = rsp_in_x_ff;
   assign rsp_last_of_window = rsp_last_ff;
   assign rsp_window_empty   = rsp_empty_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `CWAG_ASSERT_SAME(a_empty_is_last, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_last_ff && rsp_in_y_ff == '0 && rsp_in_x_ff == '0, "empty item not last or has coordinates")
   `CWAG_ASSERT_NEXT(a_last_ends_walk, clock, reset, rsp_load && load_last, state_ff == ST_IDLE, "walk continues after last item")
   `CWAG_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_load, slot_free, "response overwritten while stalled")
   `CWAG_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_accept, state_ff == ST_MUL_Y && !emitted_ff, "request did not start origin step")

endmodule

// ----- rtl/cwag_range_check.sv -----
// ----------------------------------------------------------------------------
// cwag_range_check
// Bounds test of one axis coordinate and of its next dilation step.
// ----------------------------------------------------------------------------
module cwag_range_check #(
   parameter int SW   = 21,
   parameter int STEP = 1
) (
   input  logic signed [SW-1:0]     coord,
   input  logic        [SW-1:0]     extent,
   output cwag_pkg::range_flags_type flags
);
   import cwag_pkg::*;

   logic signed [SW-1:0] coord_next;

   assign coord_next = coord + $signed(SW'(STEP));

   // extent is nonnegative and far below the signed limit
   assign flags.ok_now  = !coord[SW-1] && (coord < $signed(extent));
   assign flags.ok_next = !coord_next[SW-1] && (coord_next < $signed(extent));

endmodule
